FILE: hdl/jse_pkg.sv
// Shared types, constants and encoding functions for the JSON string escaper.
package jse_pkg;

  localparam int MAX_BYTES  = 12;
  localparam int CNT_W      = $clog2(MAX_BYTES + 1);
  localparam int IDX_W      = $clog2(MAX_BYTES);
  localparam int ESC_LEN    = 6;
  localparam int ESC_W      = $clog2(ESC_LEN + 1);
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] HEX_A_OFS = 8'h57;   // 'a' - 10

  localparam logic [5:0] HIGH_TAG = 6'b110110;
  localparam logic [5:0] LOW_TAG  = 6'b110111;
  localparam logic [4:0] SURR_TAG = 5'b11011;

  // One accepted unit's worth of output bytes.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          count;
    logic                      last;
  } desc_t;

  typedef struct packed {
    logic [ESC_LEN-1:0][7:0] bytes;
    logic [ESC_W-1:0]        count;
  } enc_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = CH_ZERO + {4'h0, v};
    end else begin
      r = HEX_A_OFS + {4'h0, v};
    end
    return r;
  endfunction

  function automatic logic [ESC_LEN-1:0][7:0] uescape(input logic [15:0] u);
    logic [ESC_LEN-1:0][7:0] r;
    r[0] = CH_BSL;
    r[1] = CH_U;
    r[2] = hex_char(u[15:12]);
    r[3] = hex_char(u[11:8]);
    r[4] = hex_char(u[7:4]);
    r[5] = hex_char(u[3:0]);
    return r;
  endfunction

  // Encode one unit on its own; a count of zero means a high surrogate is held.
  function automatic enc_t encode_unit(input logic [15:0] u, input logic last);
    enc_t r;
    r = '0;
    if (u < 16'h0080) begin
      if (u < 16'h0020 || u == 16'h0022 || u == 16'h005c) begin
        r.bytes[0] = CH_BSL;
        r.count    = ESC_W'(2);
        case (u[6:0])
          7'h22: r.bytes[1] = CH_QUOTE;
          7'h5c: r.bytes[1] = CH_BSL;
          7'h08: r.bytes[1] = CH_B;
          7'h0c: r.bytes[1] = CH_F;
          7'h0a: r.bytes[1] = CH_N;
          7'h0d: r.bytes[1] = CH_R;
          7'h09: r.bytes[1] = CH_T;
          default: begin
            r.bytes[1] = CH_U;
            r.bytes[2] = CH_ZERO;
            r.bytes[3] = CH_ZERO;
            r.bytes[4] = hex_char(u[7:4]);
            r.bytes[5] = hex_char(u[3:0]);
            r.count    = ESC_W'(ESC_LEN);
          end
        endcase
      end else begin
        r.bytes[0] = u[7:0];
        r.count    = ESC_W'(1);
      end
    end else if (u < 16'h0800) begin
      r.bytes[0] = {3'b110, u[10:6]};
      r.bytes[1] = {2'b10, u[5:0]};
      r.count    = ESC_W'(2);
    end else if (u[15:11] != SURR_TAG) begin
      r.bytes[0] = {4'b1110, u[15:12]};
      r.bytes[1] = {2'b10, u[11:6]};
      r.bytes[2] = {2'b10, u[5:0]};
      r.count    = ESC_W'(3);
    end else if (u[10] || last) begin
      r.bytes = uescape(u);
      r.count = ESC_W'(ESC_LEN);
    end
    return r;
  endfunction

endpackage

FILE: hdl/jse_front.sv
// Front end: accept code units, pair surrogates and build the byte list per unit.
module jse_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [15:0]     in_tdata,   // [15:0] code_unit
  input  logic            in_tlast,   // last_unit
  input  logic            q_full,
  output logic            q_wr_en,
  output jse_pkg::desc_t  q_wr_data
);
  import jse_pkg::*;

  logic        held_valid_r, held_valid_nxt;
  logic [15:0] held_high_r, held_high_nxt;
  logic        accept;
  logic        is_low;
  logic        is_high;
  logic [20:0] cp;
  enc_t        enc;
  desc_t       d;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign is_low    = (in_tdata[15:10] == LOW_TAG);
  assign is_high   = (in_tdata[15:10] == HIGH_TAG);
  assign cp        = {5'({1'b0, held_high_r[9:6]} + 5'd1), held_high_r[5:0], in_tdata[9:0]};
  assign enc       = encode_unit(in_tdata, in_tlast);

  always_comb begin
    d      = '0;
    d.last = in_tlast;
    if (held_valid_r && is_low) begin
      d.bytes[0] = {5'b11110, cp[20:18]};
      d.bytes[1] = {2'b10, cp[17:12]};
      d.bytes[2] = {2'b10, cp[11:6]};
      d.bytes[3] = {2'b10, cp[5:0]};
      d.count    = CNT_W'(4);
    end else if (held_valid_r) begin
      // flush the held unit, then the new unit at a fixed offset
      d.bytes[ESC_LEN-1:0]           = uescape(held_high_r);
      d.bytes[MAX_BYTES-1:ESC_LEN]   = enc.bytes;
      d.count = CNT_W'(ESC_LEN) + CNT_W'(enc.count);
    end else begin
      d.bytes[ESC_LEN-1:0] = enc.bytes;
      d.count              = CNT_W'(enc.count);
    end
  end

  assign q_wr_en   = accept && (d.count != '0);
  assign q_wr_data = d;

  always_comb begin
    held_valid_nxt = held_valid_r;
    held_high_nxt  = held_high_r;
    if (accept) begin
      held_valid_nxt = is_high && !in_tlast;
      held_high_nxt  = (is_high && !in_tlast) ? in_tdata : 16'h0000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_high_r  <= 16'h0000;
    end else begin
      held_valid_r <= held_valid_nxt;
      held_high_r  <= held_high_nxt;
    end
  end

  a_held_is_high: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> held_high_r[15:10] == HIGH_TAG)
    else $error("held unit is not a high surrogate");

  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tlast) |-> q_wr_en)
    else $error("end of string produced no bytes");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tlast) |=> !held_valid_r)
    else $error("surrogate held across end of string");

endmodule

FILE: hdl/jse_fifo.sv
// Short queue of per-unit byte lists between front and back end.
module jse_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  jse_pkg::desc_t  wr_data,
  output logic            full,
  input  logic            rd_en,
  output logic            rd_valid,
  output jse_pkg::desc_t  rd_data
);
  import jse_pkg::*;

  desc_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && full))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && !rd_valid))
    else $error("queue underflow");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("queue count out of range");

endmodule

FILE: hdl/jse_back.sv
// Back end: walk each queued byte list and drive the output register.
module jse_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  jse_pkg::desc_t  q_data,
  output logic            q_rd_en,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast   // out_last
);
  import jse_pkg::*;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic             load;
  logic             at_end;

  assign load    = q_valid && (!out_valid_r || out_tready);
  assign at_end  = (CNT_W'(idx_r) + CNT_W'(1)) == q_data.count;
  assign q_rd_en = load && at_end;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = q_data.bytes[idx_r];
      out_last_nxt  = q_data.last && at_end;
      // advance through the list, restart at the next entry
      idx_nxt       = at_end ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (q_data.count != '0 && q_data.count <= CNT_W'(MAX_BYTES)))
    else $error("queued entry has bad byte count");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> CNT_W'(idx_r) < q_data.count)
    else $error("byte index past end of entry");

  a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd_en |=> idx_r == '0)
    else $error("byte index not reset after pop");

endmodule

FILE: hdl/json_string_escape_utf8.sv
// JSON string escaper: takes one UTF-16 code unit per word (tlast marks the last
// unit of a string) and streams the JSON-escaped UTF-8 bytes of the string, one
// byte per output word, with tlast on the final byte of the string. A unit makes
// one byte for plain ASCII, two or three for other BMP characters, four for a
// surrogate pair, two or six for escapes, and up to twelve when a held high
// surrogate is flushed ahead of the next unit. The byte serializer in the back
// end emits one byte per cycle unless out_tready is low; a two-entry queue lets
// the input take one unit per cycle while the output keeps up, and a high
// surrogate that waits for its partner is accepted but makes no output byte.
module json_string_escape_utf8 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] code_unit
  input  logic        in_tlast,    // last_unit
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  output logic        out_tlast    // out_last
);
  import jse_pkg::*;

  logic  q_wr_en;
  desc_t q_wr_data;
  logic  q_full;
  logic  q_rd_en;
  logic  q_valid;
  desc_t q_data;

  jse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_wr_en   (q_wr_en),
    .q_wr_data (q_wr_data)
  );

  jse_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_wr_en),
    .wr_data  (q_wr_data),
    .full     (q_full),
    .rd_en    (q_rd_en),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  jse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_rd_en    (q_rd_en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
